// ===== hw/rtl/tcse_pkg.sv =====
`timescale 1ns / 1ps
package tcse_pkg;
   localparam int SLOTS = 8;
   localparam int SLOT_W = 3;
   localparam logic [31:0] INIT_SEQ = 32'hbeefcafe;
   localparam logic [15:0] PORT_BASE = 16'h8000;

   localparam logic [5:0] F_FIN = 6'd1;
   localparam logic [5:0] F_SYN = 6'd2;
   localparam logic [5:0] F_RST = 6'd4;
   localparam logic [5:0] F_ACK = 6'd16;

   localparam logic [1:0] OP_SEGMENT = 2'd0;
   localparam logic [1:0] OP_LISTEN  = 2'd1;
   localparam logic [1:0] OP_CONNECT = 2'd2;
   localparam logic [1:0] OP_CLOSE   = 2'd3;

   localparam logic [2:0] ST_CLOSED     = 3'd0;
   localparam logic [2:0] ST_LISTEN     = 3'd1;
   localparam logic [2:0] ST_SYN_SENT   = 3'd2;
   localparam logic [2:0] ST_SYN_RCVD   = 3'd3;
   localparam logic [2:0] ST_ESTAB      = 3'd4;
   localparam logic [2:0] ST_FIN_WAIT1  = 3'd5;
   localparam logic [2:0] ST_FIN_WAIT2  = 3'd6;
   localparam logic [2:0] ST_CLOSE_WAIT = 3'd7;

   localparam logic [2:0] N_NONE   = 3'd0;
   localparam logic [2:0] N_OPENED = 3'd1;
   localparam logic [2:0] N_FULL   = 3'd2;
   localparam logic [2:0] N_CONN   = 3'd3;
   localparam logic [2:0] N_DISC   = 3'd4;
   localparam logic [2:0] N_FREED  = 3'd5;

   // what the datapath does to a slot on the update step
   typedef struct packed {
      logic       wr_state;
      logic [2:0] state;
      logic       wr_peer;
      logic       set_expect;  // expect = seq + 1
      logic       inc_expect;
      logic       add_expect;  // expect += payload_len
      logic       set_send;    // send = init + 1
      logic       inc_send;
      logic       free;
   } upd_type;

   // one result beat
   typedef struct packed {
      logic       segment;
      logic       unmatched;
      logic       prev_seq;    // seq field is the slot send number minus one
      logic [5:0] flags;
      logic [2:0] notice;
      logic       last;
   } emit_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic                free_found;
      logic [SLOT_W-1:0]   free_slot;
      logic                used;
      logic [2:0]          state;
      logic                seq_match;
   } status_type;
endpackage

// ===== hw/rtl/tcp_connection_state_engine.sv =====
`timescale 1ns / 1ps
// Connection table engine for eight TCP slots. Each request beat (segment header, listen,
// connect or close) is accepted, matched and then used to update its slot, after which its
// result beats (at most three) are sent one at a time and the block returns to idle; a new
// request waits until then, and output stalls hold the block in the result phase.
// Results of one request come out in order with last marking the final beat.
module tcp_connection_state_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_own_address,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_peer_ip,
   input  logic [31:0] req_own_ip,
   input  logic [15:0] req_peer_port,
   input  logic [15:0] req_own_port,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_ack_num,
   input  logic [5:0]  req_flags,
   input  logic [15:0] req_payload_len,
   input  logic [2:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_segment,
   output logic [5:0]  rsp_seg_flags,
   output logic [31:0] rsp_seg_seq,
   output logic [31:0] rsp_seg_ack,
   output logic [15:0] rsp_seg_src_port,
   output logic [15:0] rsp_seg_dst_port,
   output logic [31:0] rsp_seg_dst_ip,
   output logic [2:0]  rsp_result_slot,
   output logic [2:0]  rsp_notice,
   output logic        rsp_last
);
   logic load, do_match, do_open, do_update, do_emit;
   tcse_pkg::upd_type upd;
   tcse_pkg::emit_type emit;
   tcse_pkg::status_type status;
   logic [5:0] flags;
   logic [1:0] op;

   tcse_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .flags, .op, .load, .do_match, .do_open, .do_update, .upd,
      .do_emit, .emit
   );

   tcse_datapath u_dp (
      .clock, .reset,
      .csr_write(csr_write_enable), .csr_data(csr_own_address),
      .load, .req_op, .req_peer_ip, .req_own_ip, .req_peer_port, .req_own_port,
      .req_seq_num, .req_ack_num, .req_flags, .req_payload_len, .req_slot,
      .do_match, .do_open, .do_update, .upd, .do_emit, .emit, .status, .flags, .op,
      .rsp_valid, .rsp_stall, .rsp_send_segment, .rsp_seg_flags, .rsp_seg_seq,
      .rsp_seg_ack, .rsp_seg_src_port, .rsp_seg_dst_port, .rsp_seg_dst_ip,
      .rsp_result_slot, .rsp_notice, .rsp_last
   );
endmodule

// ===== hw/rtl/tcse_datapath.sv =====
`timescale 1ns / 1ps
module tcse_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [31:0]                   csr_data,
   input  logic                          load,
   input  logic [1:0]                    req_op,
   input  logic [31:0]                   req_peer_ip,
   input  logic [31:0]                   req_own_ip,
   input  logic [15:0]                   req_peer_port,
   input  logic [15:0]                   req_own_port,
   input  logic [31:0]                   req_seq_num,
   input  logic [31:0]                   req_ack_num,
   input  logic [5:0]                    req_flags,
   input  logic [15:0]                   req_payload_len,
   input  logic [2:0]                    req_slot,
   input  logic                          do_match,
   input  logic                          do_open,
   input  logic                          do_update,
   input  tcse_pkg::upd_type             upd,
   input  logic                          do_emit,
   input  tcse_pkg::emit_type            emit,
   output tcse_pkg::status_type          status,
   output logic [5:0]                    flags,
   output logic [1:0]                    op,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_send_segment,
   output logic [5:0]                    rsp_seg_flags,
   output logic [31:0]                   rsp_seg_seq,
   output logic [31:0]                   rsp_seg_ack,
   output logic [15:0]                   rsp_seg_src_port,
   output logic [15:0]                   rsp_seg_dst_port,
   output logic [31:0]                   rsp_seg_dst_ip,
   output logic [2:0]                    rsp_result_slot,
   output logic [2:0]                    rsp_notice,
   output logic                          rsp_last
);
   localparam int SW = tcse_pkg::SLOT_W;

   logic [31:0] own_addr_ff;
   logic [15:0] next_port_ff;
   logic [tcse_pkg::SLOTS-1:0] used_ff;
   logic [2:0]  st_ff    [tcse_pkg::SLOTS];
   logic [15:0] oport_ff [tcse_pkg::SLOTS];
   logic [31:0] oip_ff   [tcse_pkg::SLOTS];
   logic [15:0] pport_ff [tcse_pkg::SLOTS];
   logic [31:0] pip_ff   [tcse_pkg::SLOTS];
   logic [31:0] snd_ff   [tcse_pkg::SLOTS];
   logic [31:0] exp_ff   [tcse_pkg::SLOTS];

   logic [1:0]  op_ff;
   logic [31:0] pip_in_ff, oip_in_ff, sq_ff, ak_ff;
   logic [15:0] pport_in_ff, oport_in_ff, plen_ff;
   logic [5:0]  fl_ff;
   logic [2:0]  slot_in_ff;
   logic        found_ff, free_found_ff;
   logic [SW-1:0] slot_ff, free_ff;

   logic          found_in, free_found_in;
   logic [SW-1:0] slot_in, free_in;

   logic        v_ff, snd_seg_ff, last_ff;
   logic [5:0]  ofl_ff;
   logic [31:0] oseq_ff, oack_ff, odip_ff;
   logic [15:0] osp_ff, odp_ff;
   logic [2:0]  oslot_ff, onote_ff;

   assign flags = fl_ff;
   assign op = op_ff;

   // highest matching slot wins
   always_comb begin
      found_in = 1'b0;
      slot_in = '0;
      free_found_in = 1'b0;
      free_in = '0;
      for (int i = 0; i < tcse_pkg::SLOTS; i++) begin
         if (used_ff[i] && oport_ff[i] == oport_in_ff && oip_ff[i] == oip_in_ff &&
             ((st_ff[i] == tcse_pkg::ST_LISTEN &&
               (fl_ff & (tcse_pkg::F_SYN | tcse_pkg::F_ACK)) == tcse_pkg::F_SYN) ||
              (pport_ff[i] == pport_in_ff && pip_ff[i] == pip_in_ff))) begin
            found_in = 1'b1;
            slot_in = SW'(i);
         end
      end
      for (int i = tcse_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found_in = 1'b1;
            free_in = SW'(i);
         end
      end
   end

   logic [SW-1:0] cur;
   always_comb begin
      cur = slot_ff;
      if (op_ff == tcse_pkg::OP_CLOSE) cur = slot_in_ff[SW-1:0];
      else if (op_ff != tcse_pkg::OP_SEGMENT) cur = free_ff;
   end

   logic close_ok;
   assign close_ok = ({1'b0, slot_in_ff} < 4'(tcse_pkg::SLOTS));

   always_comb begin
      status.found = found_ff;
      status.slot = slot_ff;
      status.free_found = free_found_ff;
      status.free_slot = free_ff;
      status.used = close_ok && used_ff[cur];
      status.state = st_ff[cur];
      status.seq_match = (sq_ff == exp_ff[cur]);
   end

   assign rsp_valid = v_ff;
   assign rsp_send_segment = snd_seg_ff;
   assign rsp_seg_flags = ofl_ff;
   assign rsp_seg_seq = oseq_ff;
   assign rsp_seg_ack = oack_ff;
   assign rsp_seg_src_port = osp_ff;
   assign rsp_seg_dst_port = odp_ff;
   assign rsp_seg_dst_ip = odip_ff;
   assign rsp_result_slot = oslot_ff;
   assign rsp_notice = onote_ff;
   assign rsp_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= '0;
         next_port_ff <= tcse_pkg::PORT_BASE;
         used_ff <= '0;
         v_ff <= 1'b0;
      end else begin
         if (csr_write) own_addr_ff <= csr_data;
         if (v_ff && !rsp_stall) v_ff <= 1'b0;
         if (do_emit) v_ff <= 1'b1;
         if (do_open) begin
            used_ff[free_ff] <= 1'b1;
            if (op_ff == tcse_pkg::OP_CONNECT) next_port_ff <= next_port_ff + 16'd1;
         end
         if (do_update && upd.free) used_ff[cur] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= req_op;
         pip_in_ff <= req_peer_ip;
         oip_in_ff <= req_own_ip;
         pport_in_ff <= req_peer_port;
         oport_in_ff <= req_own_port;
         sq_ff <= req_seq_num;
         ak_ff <= req_ack_num;
         fl_ff <= req_flags;
         plen_ff <= req_payload_len;
         slot_in_ff <= req_slot;
      end
      if (do_match) begin
         found_ff <= found_in;
         slot_ff <= slot_in;
         free_found_ff <= free_found_in;
         free_ff <= free_in;
      end
      if (do_open) begin
         oip_ff[free_ff] <= own_addr_ff;
         exp_ff[free_ff] <= '0;
         if (op_ff == tcse_pkg::OP_CONNECT) begin
            st_ff[free_ff] <= tcse_pkg::ST_SYN_SENT;
            oport_ff[free_ff] <= next_port_ff;
            pport_ff[free_ff] <= pport_in_ff;
            pip_ff[free_ff] <= pip_in_ff;
            snd_ff[free_ff] <= tcse_pkg::INIT_SEQ;
         end else begin
            st_ff[free_ff] <= tcse_pkg::ST_LISTEN;
            oport_ff[free_ff] <= oport_in_ff;
            pport_ff[free_ff] <= '0;
            pip_ff[free_ff] <= '0;
            snd_ff[free_ff] <= '0;
         end
      end
      if (do_update) begin
         if (upd.wr_state) st_ff[cur] <= upd.state;
         if (upd.wr_peer) begin
            pport_ff[cur] <= pport_in_ff;
            pip_ff[cur] <= pip_in_ff;
         end
         if (upd.set_expect) exp_ff[cur] <= sq_ff + 32'd1;
         else if (upd.inc_expect) exp_ff[cur] <= exp_ff[cur] + 32'd1;
         else if (upd.add_expect) exp_ff[cur] <= exp_ff[cur] + {16'd0, plen_ff};
         if (upd.set_send) snd_ff[cur] <= tcse_pkg::INIT_SEQ + 32'd1;
         else if (upd.inc_send) snd_ff[cur] <= snd_ff[cur] + 32'd1;
      end
      if (do_emit) begin
         snd_seg_ff <= emit.segment;
         ofl_ff <= emit.flags;
         onote_ff <= emit.notice;
         last_ff <= emit.last;
         if (emit.unmatched) begin
            oseq_ff <= ak_ff;
            oack_ff <= sq_ff + 32'd1;
            osp_ff <= oport_in_ff;
            odp_ff <= pport_in_ff;
            odip_ff <= pip_in_ff;
            oslot_ff <= '0;
         end else begin
            oslot_ff <= (emit.notice == tcse_pkg::N_FULL) ? 3'd0 : 3'(cur);
            if (emit.segment) begin
               oseq_ff <= emit.prev_seq ? snd_ff[cur] - 32'd1 : snd_ff[cur];
               oack_ff <= exp_ff[cur];
               osp_ff <= oport_ff[cur];
               odp_ff <= pport_ff[cur];
               odip_ff <= pip_ff[cur];
            end else begin
               oseq_ff <= '0;
               oack_ff <= '0;
               osp_ff <= '0;
               odp_ff <= '0;
               odip_ff <= '0;
            end
         end
      end
   end
endmodule

// ===== hw/rtl/tcse_control.sv =====
`timescale 1ns / 1ps
module tcse_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tcse_pkg::status_type   status,
   input  logic [5:0]             flags,
   input  logic [1:0]             op,
   output logic                   load,
   output logic                   do_match,
   output logic                   do_open,
   output logic                   do_update,
   output tcse_pkg::upd_type      upd,
   output logic                   do_emit,
   output tcse_pkg::emit_type     emit
);
   typedef enum logic [2:0] {S_IDLE, S_MATCH, S_PLAN, S_EMIT} state_type;

   state_type state_ff, state_in;
   tcse_pkg::emit_type q_ff [4];
   tcse_pkg::emit_type q_in [4];
   logic [2:0] cnt_ff, cnt_in, idx_ff, idx_in;

   tcse_pkg::upd_type u;
   tcse_pkg::emit_type e [4];
   logic [2:0] n;
   logic [5:0] sfa;
   logic [2:0] st;
   logic rst_out, data, closed, early;

   function automatic tcse_pkg::emit_type mk_seg(input logic [5:0] f);
      tcse_pkg::emit_type r;
      r = '0;
      r.segment = 1'b1;
      r.flags = f;
      return r;
   endfunction

   function automatic tcse_pkg::emit_type mk_note(input logic [2:0] c);
      tcse_pkg::emit_type r;
      r = '0;
      r.notice = c;
      return r;
   endfunction

   // work out the slot update and the result list for one item
   always_comb begin
      u = '0;
      for (int i = 0; i < 4; i++) e[i] = '0;
      n = 3'd0;
      rst_out = 1'b0;
      data = 1'b0;
      early = 1'b0;
      st = status.state;
      sfa = flags & (tcse_pkg::F_SYN | tcse_pkg::F_FIN | tcse_pkg::F_ACK);
      closed = 1'b0;
      case (op)
         tcse_pkg::OP_SEGMENT: begin
            if (!status.found) begin
               if (!flags[2]) begin
                  e[0] = mk_seg(tcse_pkg::F_RST);
                  e[0].unmatched = 1'b1;
                  n = 3'd1;
               end
            end else begin
               if (flags[2]) begin
                  e[0] = mk_note(tcse_pkg::N_DISC);
                  n = 3'd1;
                  closed = 1'b1;
               end else begin
                  case (sfa)
                     tcse_pkg::F_SYN: begin
                        if (st == tcse_pkg::ST_LISTEN) begin
                           u.wr_state = 1'b1;
                           u.state = tcse_pkg::ST_SYN_RCVD;
                           u.wr_peer = 1'b1;
                           u.set_expect = 1'b1;
                           u.set_send = 1'b1;
                           // slot send lands at init + 1, the syn-ack carries init
                           e[0] = mk_seg(tcse_pkg::F_SYN | tcse_pkg::F_ACK);
                           e[0].prev_seq = 1'b1;
                           n = 3'd1;
                        end else rst_out = 1'b1;
                     end
                     tcse_pkg::F_SYN | tcse_pkg::F_ACK: begin
                        if (st == tcse_pkg::ST_SYN_SENT) begin
                           u.wr_state = 1'b1;
                           u.state = tcse_pkg::ST_ESTAB;
                           u.set_expect = 1'b1;
                           u.inc_send = 1'b1;
                           e[0] = mk_seg(tcse_pkg::F_ACK);
                           e[1] = mk_note(tcse_pkg::N_CONN);
                           n = 3'd2;
                        end else rst_out = 1'b1;
                     end
                     tcse_pkg::F_SYN | tcse_pkg::F_FIN,
                     tcse_pkg::F_SYN | tcse_pkg::F_FIN | tcse_pkg::F_ACK: rst_out = 1'b1;
                     tcse_pkg::F_FIN, tcse_pkg::F_FIN | tcse_pkg::F_ACK: begin
                        if (st == tcse_pkg::ST_ESTAB) begin
                           u.wr_state = 1'b1;
                           u.state = tcse_pkg::ST_CLOSE_WAIT;
                           u.inc_expect = 1'b1;
                           e[0] = mk_seg(tcse_pkg::F_ACK);
                           e[1] = mk_seg(tcse_pkg::F_FIN | tcse_pkg::F_ACK);
                           e[2] = mk_note(tcse_pkg::N_DISC);
                           n = 3'd3;
                        end else if (st == tcse_pkg::ST_CLOSE_WAIT) begin
                           closed = 1'b1;
                        end else if (st == tcse_pkg::ST_FIN_WAIT1 ||
                                     st == tcse_pkg::ST_FIN_WAIT2) begin
                           closed = 1'b1;
                           u.inc_expect = 1'b1;
                           e[0] = mk_seg(tcse_pkg::F_ACK);
                           e[1] = mk_note(tcse_pkg::N_DISC);
                           n = 3'd2;
                        end else rst_out = 1'b1;
                     end
                     tcse_pkg::F_ACK: begin
                        if (st == tcse_pkg::ST_SYN_RCVD) begin
                           u.wr_state = 1'b1;
                           u.state = tcse_pkg::ST_ESTAB;
                           e[0] = mk_note(tcse_pkg::N_CONN);
                           n = 3'd1;
                           early = 1'b1;
                        end else if (st == tcse_pkg::ST_FIN_WAIT1) begin
                           u.wr_state = 1'b1;
                           u.state = tcse_pkg::ST_FIN_WAIT2;
                           early = 1'b1;
                        end else if (st == tcse_pkg::ST_CLOSE_WAIT) begin
                           closed = 1'b1;
                        end else if (flags != tcse_pkg::F_ACK) data = 1'b1;
                     end
                     default: data = 1'b1;
                  endcase
                  if (data) begin
                     if (status.seq_match) begin
                        u.add_expect = 1'b1;
                        e[0] = mk_seg(tcse_pkg::F_ACK);
                        n = 3'd1;
                     end else rst_out = 1'b1;
                  end
               end
               if (rst_out) begin
                  e[n[1:0]] = mk_seg(tcse_pkg::F_RST);
                  n = n + 3'd1;
               end
               if (closed && !early) begin
                  u.wr_state = 1'b1;
                  u.state = tcse_pkg::ST_CLOSED;
                  u.free = 1'b1;
                  e[n[1:0]] = mk_note(tcse_pkg::N_FREED);
                  n = n + 3'd1;
               end
            end
         end
         tcse_pkg::OP_LISTEN, tcse_pkg::OP_CONNECT: begin
            if (!status.free_found) begin
               e[0] = mk_note(tcse_pkg::N_FULL);
               n = 3'd1;
            end else if (op == tcse_pkg::OP_CONNECT) begin
               e[0] = mk_seg(tcse_pkg::F_SYN);
               e[1] = mk_note(tcse_pkg::N_OPENED);
               n = 3'd2;
            end else begin
               e[0] = mk_note(tcse_pkg::N_OPENED);
               n = 3'd1;
            end
         end
         default: begin
            if (status.used) begin
               u.wr_state = 1'b1;
               u.state = tcse_pkg::ST_FIN_WAIT1;
               u.inc_send = 1'b1;
               // fin carries the send number from before the bump
               e[0] = mk_seg(tcse_pkg::F_FIN | tcse_pkg::F_ACK);
               e[0].prev_seq = 1'b1;
               n = 3'd1;
            end
         end
      endcase
   end

   logic out_free;
   assign out_free = !rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign load = req_valid && state_ff == S_IDLE;
   assign do_match = (state_ff == S_MATCH);
   assign do_open = (state_ff == S_PLAN) && op != tcse_pkg::OP_SEGMENT &&
                    op != tcse_pkg::OP_CLOSE && status.free_found;
   assign do_update = (state_ff == S_PLAN);
   // results read the slot after the update
   assign do_emit = (state_ff == S_EMIT && out_free && idx_ff < cnt_ff);
   assign emit = q_ff[idx_ff[1:0]];

   always_comb begin
      upd = u;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      for (int i = 0; i < 4; i++) q_in[i] = q_ff[i];
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_MATCH;
         S_MATCH: state_in = S_PLAN;
         S_PLAN: begin
            for (int i = 0; i < 4; i++) q_in[i] = e[i];
            if (n != 3'd0) q_in[n[1:0] - 2'd1].last = 1'b1;
            cnt_in = n;
            idx_in = 3'd0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (idx_ff >= cnt_ff) state_in = S_IDLE;
            else if (out_free) idx_in = idx_ff + 3'd1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      for (int i = 0; i < 4; i++) q_ff[i] <= q_in[i];
   end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tcse_pkg::*;

   localparam logic [5:0] F_PSH = 6'd8;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      bit [1:0]  op;
      bit [31:0] peer_ip;
      bit [31:0] own_ip;
      bit [15:0] peer_port;
      bit [15:0] own_port;
      bit [31:0] seq_num;
      bit [31:0] ack_num;
      bit [5:0]  flags;
      bit [15:0] payload_len;
      bit [2:0]  slot;
   } request_type;

   typedef struct packed {
      bit        segment;
      bit [5:0]  flags;
      bit [31:0] seq;
      bit [31:0] ack;
      bit [15:0] src_port;
      bit [15:0] dst_port;
      bit [31:0] dst_ip;
      bit [2:0]  slot;
      bit [2:0]  notice;
      bit        last;
   } conn_result_type;

   class conn_table_model;
      bit [31:0] own_address;
      bit        used[SLOTS];
      bit [2:0]  state[SLOTS];
      bit [15:0] own_port[SLOTS];
      bit [31:0] own_ip[SLOTS];
      bit [15:0] peer_port[SLOTS];
      bit [31:0] peer_ip[SLOTS];
      bit [31:0] send_seq[SLOTS];
      bit [31:0] expect_seq[SLOTS];
      bit [15:0] next_port = PORT_BASE;
      conn_result_type pending[$];
      conn_result_type expected_results[$];
      int errors;

      task report(string msg);
         errors++;
         $display("%0t mismatch: %s", $time, msg);
      endtask

      function void put(bit sg, bit [5:0] fl, bit [31:0] sq, bit [31:0] ak,
                        bit [15:0] sp, bit [15:0] dp, bit [31:0] ip, bit [2:0] s,
                        bit [2:0] nt);
         conn_result_type r;
         r = '{sg, fl, sq, ak, sp, dp, ip, s, nt, 1'b0};
         if (pending.size() < 4) pending.insert(pending.size(), r);
      endfunction

      function void seg(int s, bit [5:0] fl);
         put(1, fl, send_seq[s], expect_seq[s], own_port[s], peer_port[s], peer_ip[s],
             s[2:0], N_NONE);
      endfunction

      function void notify(int s, bit [2:0] nt);
         put(0, 0, 0, 0, 0, 0, 0, s[2:0], nt);
      endfunction

      function void open_slot(int s, bit [2:0] st, bit [15:0] lport, bit [15:0] pport,
                              bit [31:0] pip);
         used[s] = 1;
         state[s] = st;
         own_port[s] = lport;
         own_ip[s] = own_address;
         peer_port[s] = pport;
         peer_ip[s] = pip;
         send_seq[s] = 0;
         expect_seq[s] = 0;
      endfunction

      function void segment_in(request_type r);
         int found;
         int s;
         bit rst_out;
         bit data;
         bit [2:0] st;
         found = -1;
         rst_out = 0;
         data = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!used[i] || own_port[i] != r.own_port || own_ip[i] != r.own_ip) continue;
            if (state[i] == ST_LISTEN && (r.flags & (F_SYN | F_ACK)) == F_SYN) found = i;
            else if (peer_port[i] == r.peer_port && peer_ip[i] == r.peer_ip) found = i;
         end
         if (found < 0) begin
            if (!(r.flags & F_RST))
               put(1, F_RST, r.ack_num, r.seq_num + 1, r.own_port, r.peer_port, r.peer_ip,
                   0, N_NONE);
            return;
         end
         s = found;
         if (r.flags & F_RST) begin
            state[s] = ST_CLOSED;
            notify(s, N_DISC);
         end
         if (state[s] != ST_CLOSED) begin
            st = state[s];
            case (r.flags & (F_SYN | F_ACK | F_FIN))
               F_SYN: begin
                  if (st == ST_LISTEN) begin
                     state[s] = ST_SYN_RCVD;
                     peer_port[s] = r.peer_port;
                     peer_ip[s] = r.peer_ip;
                     expect_seq[s] = r.seq_num + 1;
                     send_seq[s] = INIT_SEQ;
                     seg(s, F_SYN | F_ACK);
                     send_seq[s] += 1;
                  end else rst_out = 1;
               end
               F_SYN | F_ACK: begin
                  if (st == ST_SYN_SENT) begin
                     state[s] = ST_ESTAB;
                     expect_seq[s] = r.seq_num + 1;
                     send_seq[s] += 1;
                     seg(s, F_ACK);
                     notify(s, N_CONN);
                  end else rst_out = 1;
               end
               F_SYN | F_FIN, F_SYN | F_FIN | F_ACK: rst_out = 1;
               F_FIN, F_FIN | F_ACK: begin
                  if (st == ST_ESTAB) begin
                     state[s] = ST_CLOSE_WAIT;
                     expect_seq[s] += 1;
                     seg(s, F_ACK);
                     seg(s, F_FIN | F_ACK);
                     notify(s, N_DISC);
                  end else if (st == ST_CLOSE_WAIT) begin
                     state[s] = ST_CLOSED;
                  end else if (st == ST_FIN_WAIT1 || st == ST_FIN_WAIT2) begin
                     state[s] = ST_CLOSED;
                     expect_seq[s] += 1;
                     seg(s, F_ACK);
                     notify(s, N_DISC);
                  end else rst_out = 1;
               end
               F_ACK: begin
                  if (st == ST_SYN_RCVD) begin
                     state[s] = ST_ESTAB;
                     notify(s, N_CONN);
                     return;
                  end else if (st == ST_FIN_WAIT1) begin
                     state[s] = ST_FIN_WAIT2;
                     return;
                  end else if (st == ST_CLOSE_WAIT) begin
                     state[s] = ST_CLOSED;
                  end else if (r.flags != F_ACK) begin
                     data = 1;
                  end
               end
               default: data = 1;
            endcase
            if (data) begin
               if (r.seq_num == expect_seq[s]) begin
                  expect_seq[s] += r.payload_len;
                  seg(s, F_ACK);
               end else rst_out = 1;
            end
         end
         if (rst_out) seg(s, F_RST);
         if (state[s] == ST_CLOSED) begin
            used[s] = 0;
            notify(s, N_FREED);
         end
      endfunction

      function void note_request(request_type r);
         int f;
         pending.delete();
         case (r.op)
            OP_SEGMENT: segment_in(r);
            OP_LISTEN, OP_CONNECT: begin
               f = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) f = i;
               if (f < 0) notify(0, N_FULL);
               else begin
                  if (r.op == OP_LISTEN) open_slot(f, ST_LISTEN, r.own_port, 0, 0);
                  else begin
                     open_slot(f, ST_SYN_SENT, next_port, r.peer_port, r.peer_ip);
                     next_port += 1;
                     send_seq[f] = INIT_SEQ;
                     seg(f, F_SYN);
                  end
                  notify(f, N_OPENED);
               end
            end
            default: begin
               if (used[r.slot]) begin
                  state[r.slot] = ST_FIN_WAIT1;
                  seg(r.slot, F_FIN | F_ACK);
                  send_seq[r.slot] += 1;
               end
            end
         endcase
         if (pending.size() > 0) pending[pending.size() - 1].last = 1;
         foreach (pending[i]) expected_results.insert(expected_results.size(), pending[i]);
      endfunction

      task check_result(conn_result_type got);
         conn_result_type exp;
         string d;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result beat %p", got));
            return;
         end
         exp = expected_results.pop_front();
         d = "";
         if (got.segment != exp.segment) d = {d, " send_segment"};
         if (got.flags != exp.flags) d = {d, " seg_flags"};
         if (got.seq != exp.seq) d = {d, " seg_seq"};
         if (got.ack != exp.ack) d = {d, " seg_ack"};
         if (got.src_port != exp.src_port) d = {d, " seg_src_port"};
         if (got.dst_port != exp.dst_port) d = {d, " seg_dst_port"};
         if (got.dst_ip != exp.dst_ip) d = {d, " seg_dst_ip"};
         if (got.slot != exp.slot) d = {d, " result_slot"};
         if (got.notice != exp.notice) d = {d, " notice"};
         if (got.last != exp.last) d = {d, " last"};
         if (d != "") report($sformatf("fields%s: got %p exp %p", d, got, exp));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [31:0] csr_own_address = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = 0;
   logic [31:0] req_peer_ip = 0;
   logic [31:0] req_own_ip = 0;
   logic [15:0] req_peer_port = 0;
   logic [15:0] req_own_port = 0;
   logic [31:0] req_seq_num = 0;
   logic [31:0] req_ack_num = 0;
   logic [5:0]  req_flags = 0;
   logic [15:0] req_payload_len = 0;
   logic [2:0]  req_slot = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_send_segment;
   logic [5:0]  rsp_seg_flags;
   logic [31:0] rsp_seg_seq;
   logic [31:0] rsp_seg_ack;
   logic [15:0] rsp_seg_src_port;
   logic [15:0] rsp_seg_dst_port;
   logic [31:0] rsp_seg_dst_ip;
   logic [2:0]  rsp_result_slot;
   logic [2:0]  rsp_notice;
   logic        rsp_last;

   conn_table_model table_model = new();
   bit hold_go = 0;
   int idle_cycles = 0;

   tcp_connection_state_engine dut (.*);

   always #5 clock = ~clock;

   // receiver stall pattern, with one long hold-off on request
   int stall_mode = 0;
   int stall_count = 0;
   int hold_count = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1;
         hold_count = HOLD_CYCLES;
      end
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_count = $urandom_range(8, 80);
      end
      stall_count--;
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= (stall_count % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         table_model.check_result('{rsp_send_segment, rsp_seg_flags, rsp_seg_seq,
            rsp_seg_ack, rsp_seg_src_port, rsp_seg_dst_port, rsp_seg_dst_ip,
            rsp_result_slot, rsp_notice, rsp_last});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task send(request_type r);
      req_valid <= 1;
      req_op <= r.op;
      req_peer_ip <= r.peer_ip;
      req_own_ip <= r.own_ip;
      req_peer_port <= r.peer_port;
      req_own_port <= r.own_port;
      req_seq_num <= r.seq_num;
      req_ack_num <= r.ack_num;
      req_flags <= r.flags;
      req_payload_len <= r.payload_len;
      req_slot <= r.slot;
      do @(posedge clock); while (req_stall);
      table_model.note_request(r);
      @(negedge clock);
   endtask

   task drain_and_configure(bit [31:0] addr);
      req_valid <= 0;
      while (table_model.expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_own_address <= addr;
      @(negedge clock);
      csr_write_enable <= 0;
      table_model.own_address = addr;
   endtask

   function request_type noise();
      request_type r;
      r.op = 2'($urandom_range(0, 3));
      r.peer_ip = $urandom;
      r.own_ip = $urandom;
      r.peer_port = 16'($urandom);
      r.own_port = 16'($urandom);
      r.seq_num = $urandom;
      r.ack_num = $urandom;
      r.flags = 6'($urandom);
      r.payload_len = 16'($urandom);
      r.slot = 3'($urandom);
      return r;
   endfunction

   function request_type slot_segment(int s, bit [5:0] fl, bit in_order);
      request_type r;
      r = noise();
      r.op = OP_SEGMENT;
      r.own_port = table_model.own_port[s];
      r.own_ip = table_model.own_ip[s];
      if (table_model.state[s] != ST_LISTEN) begin
         r.peer_port = table_model.peer_port[s];
         r.peer_ip = table_model.peer_ip[s];
      end
      if (in_order) r.seq_num = table_model.expect_seq[s];
      r.flags = fl;
      r.payload_len = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 64));
      return r;
   endfunction

   function request_type op_request(bit [1:0] op, bit [15:0] port, bit [2:0] s);
      request_type r;
      r = noise();
      r.op = op;
      r.own_port = port;
      r.slot = s;
      return r;
   endfunction

   function bit [5:0] flags_for(bit [2:0] st);
      int k;
      k = $urandom_range(0, 99);
      case (st)
         ST_LISTEN: return F_SYN;
         ST_SYN_SENT: return F_SYN | F_ACK;
         ST_SYN_RCVD: return F_ACK;
         ST_ESTAB: return k < 60 ? F_ACK | F_PSH : (k < 80 ? F_ACK : F_FIN | F_ACK);
         ST_FIN_WAIT1: return k < 60 ? F_ACK : F_FIN;
         ST_FIN_WAIT2: return F_FIN | F_ACK;
         default: return k < 50 ? F_ACK : F_FIN;
      endcase
   endfunction

   function request_type random_request();
      request_type r;
      int k;
      int pick[$];
      k = $urandom_range(0, 99);
      foreach (table_model.used[i]) if (table_model.used[i]) pick.insert(pick.size(), i);
      if (k < 10) r = op_request(OP_LISTEN, 16'($urandom), 0);
      else if (k < 20) begin
         r = noise();
         r.op = OP_CONNECT;
      end
      else if (k < 26) r = op_request(OP_CLOSE, 0, 3'($urandom));
      else if (k < 86 && pick.size() > 0) begin
         k = pick[$urandom_range(0, pick.size() - 1)];
         r = slot_segment(k, flags_for(table_model.state[k]), $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) == 0) r.flags = 6'($urandom);
         else if ($urandom_range(0, 24) == 0) r.flags |= F_RST;
      end else begin
         r = noise();
         r.op = OP_SEGMENT;
      end
      return r;
   endfunction

   task random_phase(int count);
      int burst;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
            burst = $urandom_range(1, 30);
         end
         burst--;
         send(random_request());
      end
   endtask

   initial begin
      request_type r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      drain_and_configure(32'hffffffff);

      send(op_request(OP_LISTEN, 16'hffff, 0));
      r = noise();
      r.op = OP_CONNECT;
      r.peer_ip = 32'hffffffff;
      r.peer_port = 16'hffff;
      send(r);
      send(slot_segment(0, F_SYN, 0));
      send(slot_segment(0, F_ACK, 1));
      r = slot_segment(0, F_ACK | F_PSH, 1);
      r.payload_len = 16'hffff;
      send(r);
      r = slot_segment(0, F_ACK | F_PSH, 0);
      r.seq_num = table_model.expect_seq[0] + 1;
      send(r);
      send(slot_segment(1, F_SYN | F_ACK, 0));
      send(slot_segment(1, F_FIN | F_ACK, 1));
      send(slot_segment(1, F_ACK, 1));
      send(op_request(OP_CLOSE, 0, 0));
      send(slot_segment(0, F_ACK, 1));
      send(slot_segment(0, F_FIN, 1));
      send(op_request(OP_CLOSE, 0, 7));
      r = noise();
      r.op = OP_SEGMENT;
      r.flags = 0;
      send(r);
      r.flags = F_RST | F_ACK;
      send(r);
      for (int i = 0; i < SLOTS + 1; i++) send(op_request(OP_LISTEN, 16'(i), 0));
      send(slot_segment(3, F_RST, 0));

      drain_and_configure($urandom);
      hold_go = 1;
      random_phase(100);
      drain_and_configure(32'h00000000);
      random_phase(100);
      drain_and_configure($urandom);
      random_phase(100);
      drain_and_configure(32'hffffffff);
      random_phase(100);

      req_valid <= 0;
      while (table_model.expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_model.errors == 0 && table_model.expected_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
